FILE: rtl/angle_bias_kalman_filter_assert.svh
// Assertion macros for the angle/bias Kalman filter.
`ifndef ANGLE_BIAS_KALMAN_FILTER_ASSERT_SVH
`define ANGLE_BIAS_KALMAN_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ABKF_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("abkf: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ABKF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("abkf: next-cycle check failed");

`endif

FILE: rtl/abkf_pkg.sv
package abkf_pkg;

    localparam int ANGLE_W   = 32;
    localparam int COV_W     = 48;
    localparam int NOISE_W   = 47;
    localparam int DT_W      = 32;
    localparam int GAIN_W    = 41;
    localparam int FRAC_COV  = 40;
    localparam int FRAC_DT   = 32;
    localparam int CFG_IDX_W = 2;

    // shared multiplier: signed A x signed B, B consumed one digit per cycle
    localparam int MUL_A_W     = 52;
    localparam int MUL_B_W     = 48;
    localparam int MUL_DIGIT_W = 16;
    localparam int MUL_DIGITS  = MUL_B_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_PP_W    = MUL_A_W + MUL_DIGIT_W;

    // restoring divider, one quotient bit per cycle
    localparam int DIV_W     = 48;
    localparam int DIV_PRE   = DIV_W - FRAC_COV;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

    localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST = 47'd1099511628;
    localparam logic [NOISE_W-1:0] BIAS_NOISE_RST  = 47'd3298534883;
    localparam logic [NOISE_W-1:0] MEAS_NOISE_RST  = 47'd32985348977;

    localparam logic [GAIN_W-1:0] ONE_Q40  = {1'b1, {FRAC_COV{1'b0}}};
    localparam logic [DIV_W-1:0]  K1_LIMIT = {1'b0, {(DIV_W-1){1'b1}}};

    typedef struct packed {
        logic               start;
        logic               frac40;   // shift by 40 instead of 32
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [COV_W-1:0] res;
    } mul_rsp_t;

    typedef struct packed {
        logic             start;
        logic             lim_k0;     // clamp to 1.0 instead of Q8.40 max
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] res;
    } div_rsp_t;

    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return $signed(v[ANGLE_W-1:0]);
        end
    endfunction

    function automatic logic signed [COV_W-1:0] sat48(input logic signed [49:0] v);
        if (v > 50'sd140737488355327) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (v < -50'sd140737488355328) begin
            return 48'sh8000_0000_0000;
        end else begin
            return $signed(v[COV_W-1:0]);
        end
    endfunction

endpackage

FILE: rtl/abkf_mul.sv
module abkf_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  abkf_pkg::mul_req_t req,
    output abkf_pkg::mul_rsp_t rsp
);
    import abkf_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_ACC, M_FIN} mstate_t;

    mstate_t                 state_reg;
    logic                    neg_reg;
    logic                    frac40_reg;
    logic [MUL_A_W-1:0]      maga_reg;
    logic [MUL_B_W-1:0]      magb_reg;
    logic [MUL_P_W-1:0]      acc_reg;
    logic [MUL_CNT_W-1:0]    cnt_reg;
    logic signed [COV_W-1:0] res_reg;
    logic                    done_reg;

    logic [MUL_A_W-1:0]      maga_in;
    logic [MUL_B_W-1:0]      magb_in;
    logic [MUL_PP_W-1:0]     partial;
    logic [MUL_P_W-1:0]      acc_next;
    logic signed [MUL_P_W:0] prod_s;
    logic signed [MUL_P_W:0] prod_sh;
    logic signed [COV_W-1:0] res_next;

    assign maga_in = req.a[MUL_A_W-1] ? (~req.a + 1'b1) : req.a;
    assign magb_in = req.b[MUL_B_W-1] ? (~req.b + 1'b1) : req.b;

    // top digit first, accumulator shifts up one digit per cycle
    assign partial  = maga_reg * magb_reg[MUL_B_W-1 -: MUL_DIGIT_W];
    assign acc_next = {acc_reg[MUL_P_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}}
                    + MUL_P_W'(partial);

    always_comb begin
        prod_s  = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
        prod_sh = frac40_reg ? (prod_s >>> FRAC_COV) : (prod_s >>> FRAC_DT);
        if (prod_sh > 101'sd140737488355327) begin
            res_next = 48'sh7FFF_FFFF_FFFF;
        end else if (prod_sh < -101'sd140737488355328) begin
            res_next = 48'sh8000_0000_0000;
        end else begin
            res_next = $signed(prod_sh[COV_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE: begin
                    if (req.start) begin
                        neg_reg    <= req.a[MUL_A_W-1] ^ req.b[MUL_B_W-1];
                        frac40_reg <= req.frac40;
                        maga_reg   <= maga_in;
                        magb_reg   <= magb_in;
                        acc_reg    <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= M_ACC;
                    end
                end
                M_ACC: begin
                    acc_reg  <= acc_next;
                    magb_reg <= {magb_reg[MUL_B_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL_CNT_W'(MUL_DIGITS - 1)) begin
                        state_reg <= M_FIN;
                    end
                end
                M_FIN: begin
                    res_reg   <= res_next;
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

FILE: rtl/abkf_div.sv
module abkf_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  abkf_pkg::div_req_t req,
    output abkf_pkg::div_rsp_t rsp
);
    import abkf_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t              state_reg;
    logic                 ovf_reg;
    logic                 lim_k0_reg;
    logic [DIV_W-1:0]     den_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     feed_reg;
    logic [DIV_W-1:0]     q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     res_reg;
    logic                 done_reg;

    logic [DIV_W:0]       trial;
    logic                 fits;
    logic [DIV_W-1:0]     lim;

    assign trial = {rem_reg, feed_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign lim   = lim_k0_reg ? DIV_W'(ONE_Q40) : K1_LIMIT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (req.start) begin
                        // quotient needs more than DIV_W bits
                        ovf_reg    <= {{DIV_PRE{1'b0}}, req.num} >= {req.den, {DIV_PRE{1'b0}}};
                        lim_k0_reg <= req.lim_k0;
                        den_reg    <= req.den;
                        rem_reg    <= {{DIV_PRE{1'b0}}, req.num[DIV_W-1:DIV_PRE]};
                        feed_reg   <= {req.num[DIV_PRE-1:0], {FRAC_COV{1'b0}}};
                        q_reg      <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= D_RUN;
                    end
                end
                D_RUN: begin
                    rem_reg  <= fits ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
                    q_reg    <= {q_reg[DIV_W-2:0], fits};
                    feed_reg <= {feed_reg[DIV_W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN: begin
                    res_reg   <= (ovf_reg || (q_reg > lim)) ? lim : q_reg;
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

FILE: rtl/angle_bias_kalman_filter.sv
// Each request runs 4 multiplies (predict-only) or 4 + 6 multiplies and 2 divisions
//   (with correction) on the multiplier and divider, plus 3 steps: check, commit, output.
// A new request is taken only once the previous one has left the output step; that
//   step stalls while an earlier result is still held, then the next request is taken.
// Reset (aresetn low, synchronous): state and covariance cleared, noise registers
//   back to defaults, output empty.
module angle_bias_kalman_filter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [abkf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [abkf_pkg::NOISE_W-1:0]         cfg_wdata,
    // request channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [abkf_pkg::ANGLE_W-1:0]  s_gyro_rate,
    input  logic signed [abkf_pkg::ANGLE_W-1:0]  s_accel_angle,
    input  logic [abkf_pkg::DT_W-1:0]            s_time_step,
    input  logic                                 s_measurement_valid,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [abkf_pkg::ANGLE_W-1:0]  m_corrected_rate,
    output logic [abkf_pkg::GAIN_W-1:0]          m_angle_gain,
    output logic signed [abkf_pkg::ANGLE_W-1:0]  m_filtered_angle
);
    import abkf_pkg::*;

    // Sequencer: predict (4 mults), check denominator, two gain divides and six
    // update mults when correcting, commit covariance, present result.
    typedef enum logic [3:0] {
        ST_IDLE, ST_PRED_ANG, ST_PRED_T, ST_PRED_N00, ST_PRED_N11, ST_CHECK,
        ST_DIV_K0, ST_DIV_K1, ST_UPD_ANG, ST_UPD_BIAS, ST_UPD_N11, ST_UPD_N10,
        ST_UPD_N01, ST_UPD_N00, ST_COMMIT, ST_OUT
    } state_t;

    state_t state_reg;
    logic   issued_reg;     // operation launched on the shared unit, waiting on done

    // noise registers
    logic [NOISE_W-1:0] qa_reg, qb_reg, r_reg;

    // latched request
    logic signed [ANGLE_W-1:0] g_reg, acc_reg;
    logic [DT_W-1:0]           dt_reg;
    logic                      mv_reg;

    // filter state
    logic signed [ANGLE_W-1:0] angle_reg, bias_reg;
    logic signed [COV_W-1:0]   c00_reg, c01_reg, c10_reg, c11_reg;

    // working values
    logic signed [COV_W-1:0]   n00_reg, n01_reg, n10_reg, n11_reg;
    logic signed [COV_W-1:0]   t_reg, k1_reg;
    logic [GAIN_W-1:0]         k0_reg;
    logic signed [ANGLE_W:0]   y_reg;

    // output register
    logic                      m_valid_reg;
    logic signed [ANGLE_W-1:0] out_rate_reg, out_angle_reg;
    logic [GAIN_W-1:0]         out_gain_reg;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic signed [ANGLE_W:0]   rate_diff;
    logic signed [MUL_A_W-1:0] inner;
    logic signed [COV_W:0]     den;
    logic                      den_pos;
    logic [GAIN_W-1:0]         omk;
    logic [DIV_W-1:0]          n10_mag;
    logic                      mul_state;

    assign rate_diff = (ANGLE_W+1)'(g_reg) - (ANGLE_W+1)'(bias_reg);
    // dt*P11 - P01 - P10 + Qangle, exact
    assign inner = MUL_A_W'(t_reg) - MUL_A_W'(c01_reg) - MUL_A_W'(c10_reg)
                 + {{(MUL_A_W-NOISE_W){1'b0}}, qa_reg};
    assign den     = (COV_W+1)'(n00_reg) + {2'b00, r_reg};
    assign den_pos = !den[COV_W] && (den != '0);
    assign omk     = ONE_Q40 - k0_reg;
    assign n10_mag = n10_reg[COV_W-1] ? DIV_W'(-n10_reg) : DIV_W'(n10_reg);

    // operand select for the shared multiplier
    always_comb begin
        mul_state      = 1'b1;
        mul_req.frac40 = 1'b1;
        mul_req.a      = '0;
        mul_req.b      = '0;
        unique case (state_reg)
            ST_PRED_ANG: begin
                mul_req.frac40 = 1'b0;
                mul_req.a      = MUL_A_W'(rate_diff);
                mul_req.b      = {{(MUL_B_W-DT_W){1'b0}}, dt_reg};
            end
            ST_PRED_T: begin
                mul_req.frac40 = 1'b0;
                mul_req.a      = MUL_A_W'(c11_reg);
                mul_req.b      = {{(MUL_B_W-DT_W){1'b0}}, dt_reg};
            end
            ST_PRED_N00: begin
                mul_req.frac40 = 1'b0;
                mul_req.a      = inner;
                mul_req.b      = {{(MUL_B_W-DT_W){1'b0}}, dt_reg};
            end
            ST_PRED_N11: begin
                mul_req.frac40 = 1'b0;
                mul_req.a      = {{(MUL_A_W-NOISE_W){1'b0}}, qb_reg};
                mul_req.b      = {{(MUL_B_W-DT_W){1'b0}}, dt_reg};
            end
            ST_UPD_ANG: begin
                mul_req.a = {{(MUL_A_W-GAIN_W){1'b0}}, k0_reg};
                mul_req.b = MUL_B_W'(y_reg);
            end
            ST_UPD_BIAS: begin
                mul_req.a = MUL_A_W'(k1_reg);
                mul_req.b = MUL_B_W'(y_reg);
            end
            ST_UPD_N11: begin
                mul_req.a = MUL_A_W'(k1_reg);
                mul_req.b = n01_reg;
            end
            ST_UPD_N10: begin
                mul_req.a = MUL_A_W'(k1_reg);
                mul_req.b = n00_reg;
            end
            ST_UPD_N01: begin
                mul_req.a = {{(MUL_A_W-GAIN_W){1'b0}}, omk};
                mul_req.b = n01_reg;
            end
            ST_UPD_N00: begin
                mul_req.a = {{(MUL_A_W-GAIN_W){1'b0}}, omk};
                mul_req.b = n00_reg;
            end
            default: mul_state = 1'b0;
        endcase
        mul_req.start = mul_state && !issued_reg;
    end

    // K0 numerator forced to zero when n00 is not positive
    assign div_req.start  = ((state_reg == ST_DIV_K0) || (state_reg == ST_DIV_K1)) && !issued_reg;
    assign div_req.lim_k0 = (state_reg == ST_DIV_K0);
    assign div_req.num    = (state_reg == ST_DIV_K0)
                          ? ((!n00_reg[COV_W-1] && (n00_reg != '0)) ? DIV_W'(n00_reg) : '0)
                          : n10_mag;
    assign div_req.den    = den[DIV_W-1:0];

    abkf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    abkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // configuration registers; unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_reg <= ANGLE_NOISE_RST;
            qb_reg <= BIAS_NOISE_RST;
            r_reg  <= MEAS_NOISE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ANGLE_NOISE: qa_reg <= cfg_wdata;
                CFG_BIAS_NOISE:  qb_reg <= cfg_wdata;
                CFG_MEAS_NOISE:  r_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            angle_reg   <= '0;
            bias_reg    <= '0;
            c00_reg     <= '0;
            c01_reg     <= '0;
            c10_reg     <= '0;
            c11_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (mul_req.start || div_req.start) begin
                issued_reg <= 1'b1;
            end
            if (mul_rsp.done || div_rsp.done) begin
                issued_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        g_reg     <= s_gyro_rate;
                        acc_reg   <= s_accel_angle;
                        dt_reg    <= s_time_step;
                        mv_reg    <= s_measurement_valid;
                        state_reg <= ST_PRED_ANG;
                    end
                end
                ST_PRED_ANG: if (mul_rsp.done) begin
                    angle_reg <= sat32(50'(angle_reg) + 50'(mul_rsp.res));
                    state_reg <= ST_PRED_T;
                end
                ST_PRED_T: if (mul_rsp.done) begin
                    t_reg     <= mul_rsp.res;
                    state_reg <= ST_PRED_N00;
                end
                ST_PRED_N00: if (mul_rsp.done) begin
                    n00_reg   <= sat48(50'(c00_reg) + 50'(mul_rsp.res));
                    n01_reg   <= sat48(50'(c01_reg) - 50'(t_reg));
                    n10_reg   <= sat48(50'(c10_reg) - 50'(t_reg));
                    state_reg <= ST_PRED_N11;
                end
                ST_PRED_N11: if (mul_rsp.done) begin
                    n11_reg   <= sat48(50'(c11_reg) + 50'(mul_rsp.res));
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    // correction only with a measurement and a positive denominator
                    k0_reg <= '0;
                    if (mv_reg && den_pos) begin
                        y_reg     <= (ANGLE_W+1)'(acc_reg) - (ANGLE_W+1)'(angle_reg);
                        state_reg <= ST_DIV_K0;
                    end else begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_DIV_K0: if (div_rsp.done) begin
                    k0_reg    <= div_rsp.res[GAIN_W-1:0];
                    state_reg <= ST_DIV_K1;
                end
                ST_DIV_K1: if (div_rsp.done) begin
                    k1_reg    <= n10_reg[COV_W-1] ? -$signed(div_rsp.res) : $signed(div_rsp.res);
                    state_reg <= ST_UPD_ANG;
                end
                ST_UPD_ANG: if (mul_rsp.done) begin
                    angle_reg <= sat32(50'(angle_reg) + 50'(mul_rsp.res));
                    state_reg <= ST_UPD_BIAS;
                end
                ST_UPD_BIAS: if (mul_rsp.done) begin
                    bias_reg  <= sat32(50'(bias_reg) + 50'(mul_rsp.res));
                    state_reg <= ST_UPD_N11;
                end
                // in-place update: each entry is rewritten after its last read
                ST_UPD_N11: if (mul_rsp.done) begin
                    n11_reg   <= sat48(50'(n11_reg) - 50'(mul_rsp.res));
                    state_reg <= ST_UPD_N10;
                end
                ST_UPD_N10: if (mul_rsp.done) begin
                    n10_reg   <= sat48(50'(n10_reg) - 50'(mul_rsp.res));
                    state_reg <= ST_UPD_N01;
                end
                ST_UPD_N01: if (mul_rsp.done) begin
                    n01_reg   <= mul_rsp.res;
                    state_reg <= ST_UPD_N00;
                end
                ST_UPD_N00: if (mul_rsp.done) begin
                    n00_reg   <= mul_rsp.res;
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    c00_reg   <= n00_reg;
                    c01_reg   <= n01_reg;
                    c10_reg   <= n10_reg;
                    c11_reg   <= n11_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // wait for the output register to free up
                    if (!m_valid_reg || m_ready) begin
                        out_rate_reg  <= sat32(50'(g_reg) - 50'(bias_reg));
                        out_gain_reg  <= k0_reg;
                        out_angle_reg <= angle_reg;
                        m_valid_reg   <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_corrected_rate = out_rate_reg;
    assign m_angle_gain     = out_gain_reg;
    assign m_filtered_angle = out_angle_reg;

`include "angle_bias_kalman_filter_assert.svh"

    // the two arithmetic units never run at once
    `ABKF_ASSERT_IMPLY(a_one_unit, aclk, aresetn, mul_req.start, !div_req.start)
    // the angle gain never exceeds 1.0
    `ABKF_ASSERT_IMPLY(a_gain_range, aclk, aresetn, m_valid, m_angle_gain <= ONE_Q40)
    // an accepted request blocks further requests
    `ABKF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import abkf_pkg::*;

    // index 3 is decoded by nobody; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int     LONG_STALL  = 400;
    localparam int     STALL_PHASE = 4;

    typedef struct {
        logic signed [ANGLE_W-1:0] gyro;
        logic signed [ANGLE_W-1:0] accel;
        logic [DT_W-1:0]           dt;
        logic                      meas_ok;
    } imu_req_t;

    typedef struct {
        logic signed [ANGLE_W-1:0] rate;
        logic [GAIN_W-1:0]         gain;
        logic signed [ANGLE_W-1:0] angle;
    } filt_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [NOISE_W-1:0]        cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [ANGLE_W-1:0] s_gyro_rate = '0;
    logic signed [ANGLE_W-1:0] s_accel_angle = '0;
    logic [DT_W-1:0]           s_time_step = '0;
    logic                      s_measurement_valid = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [ANGLE_W-1:0] m_corrected_rate;
    logic [GAIN_W-1:0]         m_angle_gain;
    logic signed [ANGLE_W-1:0] m_filtered_angle;

    angle_bias_kalman_filter uut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Filter state mirror (widened to 64 bits, saturated as the block does)
    // ---------------------------------------------------------------
    longint est_angle, est_bias, p00, p01, p10, p11;
    longint q_angle, q_bias, r_meas;

    imu_req_t  pending_reqs[$];
    filt_out_t expected_outs[$];
    int        errors = 0;
    int        idle_pct = 28;
    int        phase = 0;
    longint    cycles = 0;

    function automatic longint clamp_signed(longint v, int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // floor(a*b / 2^sh) clamped to 48-bit signed
    function automatic longint fixmul(longint a, longint b, int sh);
        logic signed [127:0] p;
        logic signed [127:0] hi, lo;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        p = p >>> sh;
        hi = (128'sd1 <<< (COV_W - 1)) - 1;
        lo = -hi - 1;
        if (p > hi) return longint'(hi);
        if (p < lo) return longint'(lo);
        return longint'(p);
    endfunction

    // floor(num * 2^40 / den), clamped; num >= 0, den > 0
    function automatic longint gain_quotient(longint num, longint den, longint limit);
        logic [127:0] q;
        q = ({64'b0, num} << FRAC_COV) / {64'b0, den};
        if (q > {64'b0, limit}) return limit;
        return longint'(q);
    endfunction

    function automatic filt_out_t filter_update(imu_req_t r);
        longint g, acc, dt, t, inner, n00, n01, n10, n11, den, y, k1, mag, omk, m00, m01;
        longint k0;
        filt_out_t o;
        g = longint'(r.gyro);
        acc = longint'(r.accel);
        dt = longint'({32'b0, r.dt});
        k0 = 0;

        // predict
        est_angle = clamp_signed(est_angle + fixmul(g - est_bias, dt, FRAC_DT), 32);
        t = fixmul(p11, dt, FRAC_DT);
        inner = t - p01 - p10 + q_angle;
        n00 = clamp_signed(p00 + fixmul(inner, dt, FRAC_DT), 48);
        n01 = clamp_signed(p01 - t, 48);
        n10 = clamp_signed(p10 - t, 48);
        n11 = clamp_signed(p11 + fixmul(q_bias, dt, FRAC_DT), 48);

        // correct, skipped without a measurement or when the innovation variance is not positive
        if (r.meas_ok) begin
            den = n00 + r_meas;
            if (den > 0) begin
                y = acc - est_angle;
                // a negative predicted variance gives no angle gain
                k0 = (n00 > 0) ? gain_quotient(n00, den, longint'(1) <<< 40) : 0;
                mag = (n10 < 0) ? -n10 : n10;
                mag = gain_quotient(mag, den, (longint'(1) <<< 47) - 1);
                k1 = (n10 < 0) ? -mag : mag;
                est_angle = clamp_signed(est_angle + fixmul(k0, y, FRAC_COV), 32);
                est_bias = clamp_signed(est_bias + fixmul(k1, y, FRAC_COV), 32);
                omk = (longint'(1) <<< 40) - k0;
                n11 = clamp_signed(n11 - fixmul(k1, n01, FRAC_COV), 48);
                n10 = clamp_signed(n10 - fixmul(k1, n00, FRAC_COV), 48);
                m01 = fixmul(omk, n01, FRAC_COV);
                m00 = fixmul(omk, n00, FRAC_COV);
                n01 = m01;
                n00 = m00;
            end
        end
        p00 = n00; p01 = n01; p10 = n10; p11 = n11;

        o.rate = ANGLE_W'(clamp_signed(g - est_bias, 32));
        o.gain = k0[GAIN_W-1:0];
        o.angle = est_angle[ANGLE_W-1:0];
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Request driver: predicts at the accepting edge, then offers the next request
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        imu_req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                r.gyro = s_gyro_rate;
                r.accel = s_accel_angle;
                r.dt = s_time_step;
                r.meas_ok = s_measurement_valid;
                expected_outs.push_back(filter_update(r));
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
                    r = pending_reqs.pop_front();
                    s_gyro_rate <= r.gyro;
                    s_accel_angle <= r.accel;
                    s_time_step <= r.dt;
                    s_measurement_valid <= r.meas_ok;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor with random backpressure and one long hold-off
    // ---------------------------------------------------------------
    int  stall_left = 0;
    bit  stall_done = 0;

    always @(posedge aclk) begin
        filt_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outs.size() == 0) begin
                $display("%0t: unexpected result rate=%0d gain=%0d angle=%0d", $time,
                         m_corrected_rate, m_angle_gain, m_filtered_angle);
                errors++;
            end else begin
                e = expected_outs.pop_front();
                if (m_corrected_rate !== e.rate) begin
                    $display("%0t: corrected_rate expected %0d actual %0d", $time,
                             e.rate, m_corrected_rate);
                    errors++;
                end
                if (m_angle_gain !== e.gain) begin
                    $display("%0t: angle_gain expected %0d actual %0d", $time,
                             e.gain, m_angle_gain);
                    errors++;
                end
                if (m_filtered_angle !== e.angle) begin
                    $display("%0t: filtered_angle expected %0d actual %0d", $time,
                             e.angle, m_filtered_angle);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (phase == STALL_PHASE && !stall_done && m_valid) begin
            // hold results back long enough for the block to back up its input
            stall_done <= 1'b1;
            stall_left <= LONG_STALL;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NOISE_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ANGLE_NOISE: q_angle = longint'({17'b0, val});
            CFG_BIAS_NOISE:  q_bias = longint'({17'b0, val});
            CFG_MEAS_NOISE:  r_meas = longint'({17'b0, val});
            default: ;
        endcase
    endtask

    task automatic set_noise(logic [NOISE_W-1:0] qa, logic [NOISE_W-1:0] qb,
                             logic [NOISE_W-1:0] rm);
        write_reg(CFG_ANGLE_NOISE, qa);
        write_reg(CFG_BIAS_NOISE, qb);
        write_reg(CFG_MEAS_NOISE, rm);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_req(logic [31:0] g, logic [31:0] a, logic [31:0] dt, logic mv);
        imu_req_t r;
        r.gyro = g;
        r.accel = a;
        r.dt = dt;
        r.meas_ok = mv;
        pending_reqs.push_back(r);
    endtask

    // mostly plausible IMU samples, some with every bit random
    task automatic push_random(int n);
        logic [31:0] g, a, dt;
        repeat (n) begin
            if ($urandom_range(9, 0) == 0) begin
                g = $urandom();
                a = $urandom();
                dt = $urandom();
            end else begin
                g = $signed($urandom_range(2 * 500 * 65536, 0)) - 500 * 65536;
                a = $signed($urandom_range(2 * 90 * 65536, 0)) - 90 * 65536;
                dt = $urandom_range(42949673, 429497);
            end
            push_req(g, a, dt, $urandom_range(9, 0) != 0);
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_outs.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        est_angle = 0; est_bias = 0;
        p00 = 0; p01 = 0; p10 = 0; p11 = 0;
        q_angle = longint'(ANGLE_NOISE_RST);
        q_bias = longint'(BIAS_NOISE_RST);
        r_meas = longint'(MEAS_NOISE_RST);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // zero noise from a cleared covariance: denominator is zero, correction skipped
        phase = 1;
        set_noise('0, '0, '0);
        push_req(32'h0001_0000, 32'h0005_0000, 32'h0010_0000, 1'b1);
        push_req(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        push_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        drain();

        // defaults: field extremes, both measurement flags
        phase = 2;
        set_noise(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
        push_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        push_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_req(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        push_req(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b0);
        push_req(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        push_req(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        push_req(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_req(32'h0064_0000, 32'h002D_0000, 32'h0041_8937, 1'b1);
        push_req(32'hFF9C_0000, 32'hFFD3_0000, 32'h0041_8937, 1'b1);
        push_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        push_req(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        drain();

        // maximal noise: covariance runs into saturation
        phase = 3;
        set_noise({NOISE_W{1'b1}}, {NOISE_W{1'b1}}, {NOISE_W{1'b1}});
        push_random(230);
        drain();

        // defaults, no idling, then one long result hold-off
        phase = STALL_PHASE;
        idle_pct = 0;
        set_noise(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
        push_random(300);
        drain();
        idle_pct = 28;

        // zero measurement noise, tiny angle noise, large bias noise: large bias gain
        phase = 5;
        set_noise(47'd1, {NOISE_W{1'b1}}, '0);
        push_req(32'h0010_0000, 32'hFFF0_0000, 32'hFFFF_FFFF, 1'b1);
        push_random(250);
        drain();

        // random settings, plus a write to the unused index
        phase = 6;
        repeat (4) begin
            write_reg(CFG_UNUSED, NOISE_W'({$urandom(), $urandom()}));
            set_noise(NOISE_W'({$urandom(), $urandom()} >> $urandom_range(40, 0)),
                      NOISE_W'({$urandom(), $urandom()} >> $urandom_range(40, 0)),
                      NOISE_W'({$urandom(), $urandom()} >> $urandom_range(40, 0)));
            push_random(90);
            drain();
        end

        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
